@@ rtl/lscf_pkg.sv @@
// ----------------------------------------------------------------------------
// lscf_pkg: shared definitions for the algebraic circle fit
// Widths, register file map, opcodes, status codes and the solve program.
// ----------------------------------------------------------------------------
`default_nettype none

package lscf_pkg;

    localparam int COORD_BITS = 12;
    localparam int MAX_POINTS = 4096;
    localparam int FRAC_BITS  = 8;

    localparam int IN_W  = 12;
    localparam int OUT_W = 24;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int LOG_N  = $clog2(MAX_POINTS);
    localparam int SUM1_W = COORD_BITS + LOG_N;
    localparam int SUM2_W = 2 * COORD_BITS + LOG_N;
    localparam int SUM3_W = 3 * COORD_BITS + LOG_N + 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int Z_W    = 2 * COORD_BITS + 1;
    localparam int PROD_W = COORD_BITS + Z_W;

    // Wide enough for the largest intermediate, the shifted radius numerator.
    localparam int BIG_W  = 10 * COORD_BITS + 9 * LOG_N + 2 * FRAC_BITS + 12;
    localparam int ITER_W = $clog2(BIG_W + 1);

    localparam int MIN_POINTS = 3;

    // Radius square root works on a quotient below (2^(OUT_W+1)-1)^2.
    localparam int RQ_W     = 2 * (OUT_W + 1);
    localparam int SQ_STEPS = OUT_W + 1;
    localparam int SQC_W    = $clog2(SQ_STEPS + 1);
    localparam logic [RQ_W-1:0] RQ_LIMIT =
        RQ_W'(((64'd1 << (OUT_W + 1)) - 64'd1) * ((64'd1 << (OUT_W + 1)) - 64'd1));
    localparam logic [RQ_W-1:0] SQ_BIT0 = RQ_W'(1) << (RQ_W - 2);

    localparam logic [OUT_W-1:0] POS_LIM  = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_MAG  = {1'b1, {(OUT_W - 1){1'b0}}};
    localparam logic [OUT_W-1:0] RAD_SAT  = {OUT_W{1'b1}};

    // Fit status codes.
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_FEW  = 3'd1;
    localparam logic [2:0] ST_COLL = 3'd2;
    localparam logic [2:0] ST_OVF  = 3'd3;
    localparam logic [2:0] ST_SAT  = 3'd4;

    // Register file map.
    localparam int RF_DEPTH = 32;
    localparam int ADDR_W   = $clog2(RF_DEPTH);
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_addr R_N    = 5'd0;
    localparam t_addr R_SX   = 5'd1;
    localparam t_addr R_SY   = 5'd2;
    localparam t_addr R_SXX  = 5'd3;
    localparam t_addr R_SYY  = 5'd4;
    localparam t_addr R_SXY  = 5'd5;
    localparam t_addr R_S3X  = 5'd6;
    localparam t_addr R_S3Y  = 5'd7;
    localparam t_addr R_SZ   = 5'd8;
    localparam t_addr R_T1   = 5'd9;
    localparam t_addr R_T2   = 5'd10;
    localparam t_addr R_CXX  = 5'd11;
    localparam t_addr R_CYY  = 5'd12;
    localparam t_addr R_CXY  = 5'd13;
    localparam t_addr R_CXZ  = 5'd14;
    localparam t_addr R_CYZ  = 5'd15;
    localparam t_addr R_DD   = 5'd16;
    localparam t_addr R_E    = 5'd17;
    localparam t_addr R_NA   = 5'd18;
    localparam t_addr R_NB   = 5'd19;
    localparam t_addr R_M    = 5'd20;
    localparam t_addr R_D2   = 5'd21;
    localparam t_addr R_Q    = 5'd22;
    localparam t_addr R_RN   = 5'd23;
    localparam t_addr R_RD   = 5'd24;
    localparam t_addr R_ACC  = 5'd25;

    // The sums are loaded into entries R_N through R_S3Y.
    localparam int NUM_SUMS = 8;
    localparam int LD_W     = $clog2(NUM_SUMS);
    localparam logic [LD_W-1:0] LD_LAST = LD_W'(NUM_SUMS - 1);

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_ABS,
        OP_CLAMP,
        OP_SHL_C,
        OP_SHL_R,
        OP_CHKD,
        OP_FINX,
        OP_FINY,
        OP_FINR
    } t_op;

    typedef struct packed {
        t_op   op;
        t_addr dst;
        t_addr a;
        t_addr b;
    } t_instr;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_cmd;

    localparam int PC_W = 6;

    function automatic logic is_alu_op(input t_op op);
        logic r;
        case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_ABS, OP_CLAMP, OP_SHL_C, OP_SHL_R: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_instr mk(input t_op op, input t_addr d, input t_addr a,
                                  input t_addr b);
        t_instr i;
        i.op  = op;
        i.dst = d;
        i.a   = a;
        i.b   = b;
        return i;
    endfunction

    // Solve program: centered moments, determinant, center numerators,
    // rounded centers, then the radius from the mean squared distance.
    function automatic t_instr prog(input logic [PC_W-1:0] pc);
        t_instr ins;
        unique case (pc)
            6'd0:  ins = mk(OP_ADD,   R_SZ,  R_SXX, R_SYY);
            6'd1:  ins = mk(OP_MUL,   R_T1,  R_N,   R_SXX);
            6'd2:  ins = mk(OP_MUL,   R_T2,  R_SX,  R_SX);
            6'd3:  ins = mk(OP_SUB,   R_CXX, R_T1,  R_T2);
            6'd4:  ins = mk(OP_MUL,   R_T1,  R_N,   R_SYY);
            6'd5:  ins = mk(OP_MUL,   R_T2,  R_SY,  R_SY);
            6'd6:  ins = mk(OP_SUB,   R_CYY, R_T1,  R_T2);
            6'd7:  ins = mk(OP_MUL,   R_T1,  R_N,   R_SXY);
            6'd8:  ins = mk(OP_MUL,   R_T2,  R_SX,  R_SY);
            6'd9:  ins = mk(OP_SUB,   R_CXY, R_T1,  R_T2);
            6'd10: ins = mk(OP_MUL,   R_T1,  R_N,   R_S3X);
            6'd11: ins = mk(OP_MUL,   R_T2,  R_SX,  R_SZ);
            6'd12: ins = mk(OP_SUB,   R_CXZ, R_T1,  R_T2);
            6'd13: ins = mk(OP_MUL,   R_T1,  R_N,   R_S3Y);
            6'd14: ins = mk(OP_MUL,   R_T2,  R_SY,  R_SZ);
            6'd15: ins = mk(OP_SUB,   R_CYZ, R_T1,  R_T2);
            6'd16: ins = mk(OP_MUL,   R_T1,  R_CXX, R_CYY);
            6'd17: ins = mk(OP_MUL,   R_T2,  R_CXY, R_CXY);
            6'd18: ins = mk(OP_SUB,   R_DD,  R_T1,  R_T2);
            6'd19: ins = mk(OP_CHKD,  R_DD,  R_DD,  R_DD);
            6'd20: ins = mk(OP_ADD,   R_E,   R_DD,  R_DD);
            6'd21: ins = mk(OP_MUL,   R_T1,  R_CXZ, R_CYY);
            6'd22: ins = mk(OP_MUL,   R_T2,  R_CYZ, R_CXY);
            6'd23: ins = mk(OP_SUB,   R_NA,  R_T1,  R_T2);
            6'd24: ins = mk(OP_MUL,   R_T1,  R_CYZ, R_CXX);
            6'd25: ins = mk(OP_MUL,   R_T2,  R_CXZ, R_CXY);
            6'd26: ins = mk(OP_SUB,   R_NB,  R_T1,  R_T2);
            6'd27: ins = mk(OP_ADD,   R_D2,  R_E,   R_E);
            6'd28: ins = mk(OP_ABS,   R_M,   R_NA,  R_NA);
            6'd29: ins = mk(OP_SHL_C, R_M,   R_M,   R_M);
            6'd30: ins = mk(OP_ADD,   R_M,   R_M,   R_E);
            6'd31: ins = mk(OP_DIV,   R_Q,   R_M,   R_D2);
            6'd32: ins = mk(OP_FINX,  R_Q,   R_Q,   R_NA);
            6'd33: ins = mk(OP_ABS,   R_M,   R_NB,  R_NB);
            6'd34: ins = mk(OP_SHL_C, R_M,   R_M,   R_M);
            6'd35: ins = mk(OP_ADD,   R_M,   R_M,   R_E);
            6'd36: ins = mk(OP_DIV,   R_Q,   R_M,   R_D2);
            6'd37: ins = mk(OP_FINY,  R_Q,   R_Q,   R_NB);
            6'd38: ins = mk(OP_MUL,   R_T1,  R_NA,  R_NA);
            6'd39: ins = mk(OP_MUL,   R_T2,  R_NB,  R_NB);
            6'd40: ins = mk(OP_ADD,   R_T1,  R_T1,  R_T2);
            6'd41: ins = mk(OP_MUL,   R_RN,  R_N,   R_T1);
            6'd42: ins = mk(OP_MUL,   R_ACC, R_E,   R_SZ);
            6'd43: ins = mk(OP_MUL,   R_T1,  R_NA,  R_SX);
            6'd44: ins = mk(OP_ADD,   R_T1,  R_T1,  R_T1);
            6'd45: ins = mk(OP_SUB,   R_ACC, R_ACC, R_T1);
            6'd46: ins = mk(OP_MUL,   R_T1,  R_NB,  R_SY);
            6'd47: ins = mk(OP_ADD,   R_T1,  R_T1,  R_T1);
            6'd48: ins = mk(OP_SUB,   R_ACC, R_ACC, R_T1);
            6'd49: ins = mk(OP_MUL,   R_ACC, R_ACC, R_E);
            6'd50: ins = mk(OP_ADD,   R_RN,  R_RN,  R_ACC);
            6'd51: ins = mk(OP_CLAMP, R_RN,  R_RN,  R_RN);
            6'd52: ins = mk(OP_MUL,   R_RD,  R_E,   R_E);
            6'd53: ins = mk(OP_MUL,   R_RD,  R_RD,  R_N);
            6'd54: ins = mk(OP_SHL_R, R_RN,  R_RN,  R_RN);
            6'd55: ins = mk(OP_DIV,   R_Q,   R_RN,  R_RD);
            default: ins = mk(OP_FINR, R_Q,  R_Q,   R_Q);
        endcase
        return ins;
    endfunction

endpackage

`default_nettype wire

@@ rtl/least_squares_circle_fit_top.sv @@
// A point is accepted, then takes five multiply steps on one small multiplier.
// The last point adds a solve: 57 program steps, among them 25 shift-add multiplies
// and 3 divides that hold the wait state on the shared wide unit, then 25 square
// root steps. One point is in work at a time.
// Reset is synchronous, active low, and clears the sums, the count and the handshake.
// ----------------------------------------------------------------------------
// least_squares_circle_fit_top: algebraic least-squares circle fit
// Accumulates contour point moments, then solves for center and radius in
// exact integer arithmetic with a microprogrammed wide arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

module least_squares_circle_fit_top import lscf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [IN_W-1:0]         i_point_x,
    input  logic [IN_W-1:0]         i_point_y,
    input  logic                    i_last_point,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_center_x,
    output logic signed [OUT_W-1:0] o_center_y,
    output logic [OUT_W-1:0]        o_radius,
    output logic [2:0]              o_fit_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_PT, S_PRE, S_LOAD, S_FETCH, S_ISSUE, S_WAIT, S_SQRT, S_OUT
    } t_state;

    typedef enum logic [2:0] {P_XX, P_YY, P_XY, P_XZ, P_YZ} t_pstep;

    t_state r_state;
    t_pstep r_step;

    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic                  r_last;
    logic [SQ_W-1:0]       r_pxx;
    logic [SQ_W-1:0]       r_pyy;
    logic [Z_W-1:0]        r_pz;

    logic [CNT_W-1:0]  r_cnt;
    logic [SUM1_W-1:0] r_sum_x;
    logic [SUM1_W-1:0] r_sum_y;
    logic [SUM2_W-1:0] r_sum_xx;
    logic [SUM2_W-1:0] r_sum_yy;
    logic [SUM2_W-1:0] r_sum_xy;
    logic [SUM3_W-1:0] r_sum3x;
    logic [SUM3_W-1:0] r_sum3y;
    logic              r_ovf;

    logic [LD_W-1:0]   r_ld;
    logic [PC_W-1:0]   r_pc;
    logic              r_sat;

    logic [RQ_W-1:0]   r_sq_v;
    logic [RQ_W-1:0]   r_sq_res;
    logic [RQ_W-1:0]   r_sq_bit;
    logic [SQC_W-1:0]  r_sq_cnt;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_cx;
    logic [OUT_W-1:0]  r_cy;
    logic [OUT_W-1:0]  r_rad;
    logic [2:0]        r_status;

    // Point moment multiplier.
    logic [COORD_BITS-1:0] mul_a;
    logic [Z_W-1:0]        mul_b;
    logic [PROD_W-1:0]     prod;

    always_comb begin
        unique case (r_step)
            P_XX: begin
                mul_a = r_px;
                mul_b = Z_W'(r_px);
            end
            P_YY: begin
                mul_a = r_py;
                mul_b = Z_W'(r_py);
            end
            P_XY: begin
                mul_a = r_px;
                mul_b = Z_W'(r_py);
            end
            P_XZ: begin
                mul_a = r_px;
                mul_b = r_pz;
            end
            default: begin
                mul_a = r_py;
                mul_b = r_pz;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Register file and shared unit.
    t_instr           instr;
    t_alu_cmd         alu_cmd;
    logic             alu_done;
    logic [BIG_W-1:0] alu_res;
    logic [BIG_W-1:0] rd_a;
    logic [BIG_W-1:0] rd_b;
    logic             ram_we;
    t_addr            ram_waddr;
    logic [BIG_W-1:0] ram_wdata;
    t_addr            ld_addr;
    logic [BIG_W-1:0] ld_data;

    assign instr = prog(r_pc);

    assign ld_addr = ADDR_W'(r_ld);

    always_comb begin
        unique case (ld_addr)
            R_N:     ld_data = BIG_W'(r_cnt);
            R_SX:    ld_data = BIG_W'(r_sum_x);
            R_SY:    ld_data = BIG_W'(r_sum_y);
            R_SXX:   ld_data = BIG_W'(r_sum_xx);
            R_SYY:   ld_data = BIG_W'(r_sum_yy);
            R_SXY:   ld_data = BIG_W'(r_sum_xy);
            R_S3X:   ld_data = BIG_W'(r_sum3x);
            default: ld_data = BIG_W'(r_sum3y);
        endcase
    end

    assign ram_we    = (r_state == S_LOAD) || ((r_state == S_WAIT) && alu_done);
    assign ram_waddr = (r_state == S_LOAD) ? ld_addr : instr.dst;
    assign ram_wdata = (r_state == S_LOAD) ? ld_data : alu_res;

    assign alu_cmd.start = (r_state == S_ISSUE) && is_alu_op(instr.op);
    assign alu_cmd.op    = instr.op;

    lscf_ram #(
        .WIDTH (BIG_W),
        .DEPTH (RF_DEPTH)
    ) u_rf (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (instr.a),
        .i_raddr_b (instr.b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    lscf_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (alu_cmd),
        .i_a     (rd_a),
        .i_b     (rd_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // Center rounding result: operand a is the quotient, b the signed numerator.
    logic             fx_neg;
    logic             fx_big;
    logic [OUT_W-1:0] fx_q;
    logic [OUT_W-1:0] fx_val;

    assign fx_neg = rd_b[BIG_W-1];
    assign fx_q   = rd_a[OUT_W-1:0];
    assign fx_big = (|rd_a[BIG_W-1:OUT_W]) || (fx_neg ? (fx_q > NEG_MAG) : (fx_q > POS_LIM));
    assign fx_val = fx_big ? (fx_neg ? NEG_MAG : POS_LIM) : (fx_neg ? -fx_q : fx_q);

    logic fr_big;
    assign fr_big = (|rd_a[BIG_W-1:RQ_W]) || (rd_a[RQ_W-1:0] >= RQ_LIMIT);

    logic            dd_bad;
    assign dd_bad = rd_a[BIG_W-1] || (rd_a == '0);

    logic [RQ_W-1:0] sq_try;
    logic            sq_ge;
    logic [RQ_W-1:0] sq_round;

    assign sq_try   = r_sq_res + r_sq_bit;
    assign sq_ge    = r_sq_v >= sq_try;
    assign sq_round = r_sq_res + RQ_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= P_XX;
            r_cnt       <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_xx    <= '0;
            r_sum_yy    <= '0;
            r_sum_xy    <= '0;
            r_sum3x     <= '0;
            r_sum3y     <= '0;
            r_ovf       <= 1'b0;
            r_ld        <= '0;
            r_pc        <= '0;
            r_sat       <= 1'b0;
            r_sq_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_px   <= i_point_x[COORD_BITS-1:0];
                        r_py   <= i_point_y[COORD_BITS-1:0];
                        r_last <= i_last_point;
                        if (r_cnt >= CNT_W'(MAX_POINTS)) begin
                            r_ovf   <= 1'b1;
                            r_state <= i_last_point ? S_PRE : S_IDLE;
                        end else begin
                            r_step  <= P_XX;
                            r_state <= S_PT;
                        end
                    end
                end
                S_PT: begin
                    unique case (r_step)
                        P_XX: begin
                            r_pxx  <= prod[SQ_W-1:0];
                            r_step <= P_YY;
                        end
                        P_YY: begin
                            r_pyy  <= prod[SQ_W-1:0];
                            r_step <= P_XY;
                        end
                        P_XY: begin
                            r_sum_xy <= r_sum_xy + SUM2_W'(prod[SQ_W-1:0]);
                            r_pz     <= Z_W'(r_pxx) + Z_W'(r_pyy);
                            r_step   <= P_XZ;
                        end
                        P_XZ: begin
                            r_sum3x <= r_sum3x + SUM3_W'(prod);
                            r_step  <= P_YZ;
                        end
                        default: begin
                            r_sum3y  <= r_sum3y + SUM3_W'(prod);
                            r_sum_x  <= r_sum_x + SUM1_W'(r_px);
                            r_sum_y  <= r_sum_y + SUM1_W'(r_py);
                            r_sum_xx <= r_sum_xx + SUM2_W'(r_pxx);
                            r_sum_yy <= r_sum_yy + SUM2_W'(r_pyy);
                            r_cnt    <= r_cnt + CNT_W'(1);
                            r_state  <= r_last ? S_PRE : S_IDLE;
                        end
                    endcase
                end
                S_PRE: begin
                    if (r_cnt < CNT_W'(MIN_POINTS)) begin
                        r_cx        <= '0;
                        r_cy        <= '0;
                        r_rad       <= '0;
                        r_status    <= ST_FEW;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_ld    <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_ld <= r_ld + 1'b1;
                    if (r_ld == LD_LAST) begin
                        r_pc    <= '0;
                        r_sat   <= 1'b0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_ISSUE;
                end
                S_ISSUE: begin
                    priority case (instr.op)
                        OP_CHKD: begin
                            if (dd_bad) begin
                                r_cx        <= '0;
                                r_cy        <= '0;
                                r_rad       <= '0;
                                r_status    <= ST_COLL;
                                r_out_valid <= 1'b1;
                                r_state     <= S_OUT;
                            end else begin
                                r_pc    <= r_pc + 1'b1;
                                r_state <= S_FETCH;
                            end
                        end
                        OP_FINX: begin
                            r_cx    <= fx_val;
                            r_sat   <= r_sat | fx_big;
                            r_pc    <= r_pc + 1'b1;
                            r_state <= S_FETCH;
                        end
                        OP_FINY: begin
                            r_cy    <= fx_val;
                            r_sat   <= r_sat | fx_big;
                            r_pc    <= r_pc + 1'b1;
                            r_state <= S_FETCH;
                        end
                        OP_FINR: begin
                            if (fr_big) begin
                                r_rad       <= RAD_SAT;
                                r_status    <= r_ovf ? ST_OVF : ST_SAT;
                                r_out_valid <= 1'b1;
                                r_state     <= S_OUT;
                            end else begin
                                r_sq_v   <= rd_a[RQ_W-1:0];
                                r_sq_res <= '0;
                                r_sq_bit <= SQ_BIT0;
                                r_sq_cnt <= SQC_W'(SQ_STEPS);
                                r_state  <= S_SQRT;
                            end
                        end
                        default: begin
                            r_state <= S_WAIT;
                        end
                    endcase
                end
                S_WAIT: begin
                    if (alu_done) begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= S_FETCH;
                    end
                end
                S_SQRT: begin
                    if (r_sq_cnt == '0) begin
                        r_rad       <= sq_round[OUT_W:1];
                        r_status    <= r_ovf ? ST_OVF : (r_sat ? ST_SAT : ST_OK);
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        if (sq_ge) begin
                            r_sq_v   <= r_sq_v - sq_try;
                            r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                        end else begin
                            r_sq_res <= r_sq_res >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                        r_sq_cnt <= r_sq_cnt - 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        // Word taken: clear valid, sums, count and overflow.
                        r_out_valid <= 1'b0;
                        r_cnt       <= '0;
                        r_sum_x     <= '0;
                        r_sum_y     <= '0;
                        r_sum_xx    <= '0;
                        r_sum_yy    <= '0;
                        r_sum_xy    <= '0;
                        r_sum3x     <= '0;
                        r_sum3y     <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_center_x   = signed'(r_cx);
    assign o_center_y   = signed'(r_cy);
    assign o_radius     = r_rad;
    assign o_fit_status = r_status;

endmodule

`default_nettype wire

@@ rtl/lscf_ram.sv @@
// ----------------------------------------------------------------------------
// lscf_ram: generic register file memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lscf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

@@ rtl/lscf_alu.sv @@
// ----------------------------------------------------------------------------
// lscf_alu: shared wide arithmetic unit
// Registered add, subtract, abs, clamp and shifts; shift-add multiply and
// restoring divide one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lscf_alu import lscf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_alu_cmd         i_cmd,
    input  logic [BIG_W-1:0] i_a,
    input  logic [BIG_W-1:0] i_b,
    output logic             o_done,
    output logic [BIG_W-1:0] o_res
);

    logic              r_busy;
    logic              r_done;
    t_op               r_op;
    logic [BIG_W-1:0]  r_acc;
    logic [BIG_W-1:0]  r_x;
    logic [BIG_W-1:0]  r_y;
    logic [BIG_W-1:0]  r_res;
    logic              r_neg;
    logic [ITER_W-1:0] r_cnt;

    logic [BIG_W-1:0] abs_a;
    logic [BIG_W-1:0] abs_b;
    logic [BIG_W-1:0] div_sh;
    logic [BIG_W-1:0] div_diff;
    logic             div_ge;

    assign abs_a    = i_a[BIG_W-1] ? -i_a : i_a;
    assign abs_b    = i_b[BIG_W-1] ? -i_b : i_b;
    // For a divide, r_x is the remainder, r_y the dividend turning into the
    // quotient, and r_acc the divisor.
    assign div_sh   = {r_x[BIG_W-2:0], r_y[BIG_W-1]};
    assign div_diff = div_sh - r_acc;
    assign div_ge   = div_sh >= r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_op <= i_cmd.op;
                unique case (i_cmd.op)
                    OP_ADD: begin
                        r_res  <= i_a + i_b;
                        r_done <= 1'b1;
                    end
                    OP_SUB: begin
                        r_res  <= i_a - i_b;
                        r_done <= 1'b1;
                    end
                    OP_ABS: begin
                        r_res  <= abs_a;
                        r_done <= 1'b1;
                    end
                    OP_CLAMP: begin
                        r_res  <= i_a[BIG_W-1] ? '0 : i_a;
                        r_done <= 1'b1;
                    end
                    OP_SHL_C: begin
                        r_res  <= i_a << (FRAC_BITS + 1);
                        r_done <= 1'b1;
                    end
                    OP_SHL_R: begin
                        r_res  <= i_a << (2 * FRAC_BITS + 2);
                        r_done <= 1'b1;
                    end
                    OP_MUL: begin
                        r_acc  <= '0;
                        r_x    <= abs_a;
                        r_y    <= abs_b;
                        r_neg  <= i_a[BIG_W-1] ^ i_b[BIG_W-1];
                        r_busy <= 1'b1;
                    end
                    OP_DIV: begin
                        r_acc  <= i_b;
                        r_x    <= '0;
                        r_y    <= i_a;
                        r_cnt  <= ITER_W'(BIG_W);
                        r_busy <= 1'b1;
                    end
                    default: begin
                        r_res  <= i_a;
                        r_done <= 1'b1;
                    end
                endcase
            end else if (r_busy) begin
                if (r_op == OP_MUL) begin
                    if (r_y == '0) begin
                        r_res  <= r_neg ? -r_acc : r_acc;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end else begin
                        if (r_y[0]) begin
                            r_acc <= r_acc + r_x;
                        end
                        r_x <= r_x << 1;
                        r_y <= r_y >> 1;
                    end
                end else begin
                    if (r_cnt == '0) begin
                        r_res  <= r_y;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end else begin
                        r_x   <= div_ge ? div_diff : div_sh;
                        r_y   <= {r_y[BIG_W-2:0], div_ge};
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

@@ dv/least_squares_circle_fit_top_tb.sv @@
// ----------------------------------------------------------------------------
// least_squares_circle_fit_top_tb: testbench for the algebraic circle fit
// Streams contour points into the block under random bursts and output stalls.
// An exact-integer fit predictor builds the expected center, radius and status
// of every contour, and a scoreboard checks each word of the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module least_squares_circle_fit_top_tb import lscf_pkg::*; ();

    localparam int  LIMIT_CYCLES = 4_000_000;
    localparam int  FW           = 512;
    typedef logic [FW-1:0] t_wide;

    typedef struct {
        logic [OUT_W-1:0] cx;
        logic [OUT_W-1:0] cy;
        logic [OUT_W-1:0] rad;
        logic [2:0]       st;
    } t_fit;

    class fit_scoreboard;
        t_fit        fits_due[$];
        int          n_pts;
        logic [63:0] sx, sy, sxx, syy, sxy, s3x, s3y;
        logic        ovf;
        int          errors;

        function new();
            errors = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            n_pts = 0; ovf = 1'b0;
            sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0; s3x = 0; s3y = 0;
        endfunction

        function automatic logic [63:0] sqrt64(input logic [63:0] v);
            logic [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // Rounds num * 2^FRAC_BITS / e to nearest, ties away from zero.
        function automatic logic round_center(input t_wide num, input t_wide e,
                                              output logic [OUT_W-1:0] res);
            t_wide m, q;
            logic  neg;
            neg = num[FW-1];
            m = neg ? -num : num;
            m = (m << (FRAC_BITS + 1)) + e;
            q = m / (e + e);
            if (q > (neg ? t_wide'(NEG_MAG) : t_wide'(POS_LIM))) begin
                res = neg ? NEG_MAG : POS_LIM;
                return 1'b1;
            end
            res = neg ? OUT_W'(-q) : OUT_W'(q);
            return 1'b0;
        endfunction

        function automatic t_fit solve_fit();
            t_fit  f;
            t_wide n, sz, cxx, cyy, cxy, cxz, cyz, dd, e, na, nb, rn, rd, acc, q;
            logic  sat;
            f.cx = 0; f.cy = 0; f.rad = 0;
            if (n_pts < MIN_POINTS) begin
                f.st = ST_FEW;
                return f;
            end
            n   = t_wide'(n_pts);
            sz  = t_wide'(sxx) + t_wide'(syy);
            cxx = n * t_wide'(sxx) - t_wide'(sx) * t_wide'(sx);
            cyy = n * t_wide'(syy) - t_wide'(sy) * t_wide'(sy);
            cxy = n * t_wide'(sxy) - t_wide'(sx) * t_wide'(sy);
            cxz = n * t_wide'(s3x) - t_wide'(sx) * sz;
            cyz = n * t_wide'(s3y) - t_wide'(sy) * sz;
            dd  = cxx * cyy - cxy * cxy;
            if (dd == 0 || dd[FW-1]) begin
                f.st = ST_COLL;
                return f;
            end
            e  = dd + dd;
            na = cxz * cyy - cyz * cxy;
            nb = cyz * cxx - cxz * cxy;
            sat = round_center(na, e, f.cx);
            sat = round_center(nb, e, f.cy) || sat;
            rn  = n * (na * na + nb * nb);
            acc = e * sz - 2 * na * t_wide'(sx) - 2 * nb * t_wide'(sy);
            rn  = rn + acc * e;
            if (rn[FW-1]) rn = 0;
            rd = e * e * n;
            q  = (rn << (2 * FRAC_BITS + 2)) / rd;
            if (q >= t_wide'(RQ_LIMIT)) begin
                f.rad = RAD_SAT;
                sat = 1'b1;
            end else begin
                f.rad = OUT_W'((sqrt64(q[63:0]) + 1) >> 1);
            end
            f.st = ovf ? ST_OVF : (sat ? ST_SAT : ST_OK);
            return f;
        endfunction

        function void note_point(input logic [IN_W-1:0] px, input logic [IN_W-1:0] py,
                                 input logic lst);
            logic [63:0] x, y;
            x = 64'(px);
            y = 64'(py);
            if (n_pts < MAX_POINTS) begin
                n_pts++;
                sx += x; sy += y;
                sxx += x * x; syy += y * y; sxy += x * y;
                s3x += x * x * x + x * y * y;
                s3y += x * x * y + y * y * y;
            end else begin
                ovf = 1'b1;
            end
            if (lst) begin
                fits_due = {fits_due, solve_fit()};
                clear_sums();
            end
        endfunction

        function void check_fit(input t_fit got);
            t_fit want;
            if (fits_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected fit cx=%h cy=%h r=%h st=%0d",
                             got.cx, got.cy, got.rad, got.st);
                return;
            end
            want = fits_due.pop_front();
            if (got.cx !== want.cx || got.cy !== want.cy || got.rad !== want.rad
                    || got.st !== want.st) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: fit exp cx=%h cy=%h r=%h st=%0d got cx=%h cy=%h r=%h st=%0d",
                             want.cx, want.cy, want.rad, want.st,
                             got.cx, got.cy, got.rad, got.st);
            end
        endfunction

        function int pending();
            return fits_due.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [IN_W-1:0]         i_point_x;
    logic [IN_W-1:0]         i_point_y;
    logic                    i_last_point;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [OUT_W-1:0] o_center_x;
    logic signed [OUT_W-1:0] o_center_y;
    logic [OUT_W-1:0]        o_radius;
    logic [2:0]              o_fit_status;

    fit_scoreboard sb;
    int            cycle_cnt;
    int            stall_mode;
    int            points_sent;

    least_squares_circle_fit_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_center_x   (o_center_x),
        .o_center_y   (o_center_y),
        .o_radius     (o_radius),
        .o_fit_status (o_fit_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver switches between free-running, random and heavy stall modes.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: i_ready = 1'b1;
            1: i_ready = 1'($urandom_range(0, 1));
            default: i_ready = ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_fit got;
        if (i_rst_n && o_valid && i_ready) begin
            got.cx = o_center_x;
            got.cy = o_center_y;
            got.rad = o_radius;
            got.st = o_fit_status;
            sb.check_fit(got);
        end
    end

    task automatic send_point(input int x, input int y, input bit lst);
        @(negedge i_clk);
        i_valid = 1'b1;
        i_point_x = IN_W'(x);
        i_point_y = IN_W'(y);
        i_last_point = lst;
        do @(posedge i_clk); while (!o_ready);
        sb.note_point(IN_W'(x), IN_W'(y), lst);
        points_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            i_point_x = IN_W'($urandom);
            i_point_y = IN_W'($urandom);
            i_last_point = 1'($urandom_range(0, 1));
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        idle_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic int clip(input int v);
        return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
    endfunction

    // One contour of random shape; the sender breaks it into bursts.
    task automatic send_contour();
        int  kind, len, k, x, y, cxp, cyp, r, x0, y0, dx, dy, burst;
        real ang;
        kind = $urandom_range(0, 9);
        len = (kind == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
        if ($urandom_range(0, 19) == 0) len = $urandom_range(41, 200);
        cxp = $urandom_range(0, 4095);
        cyp = $urandom_range(0, 4095);
        r   = $urandom_range(1, 2500);
        x0  = $urandom_range(0, 4095);
        y0  = $urandom_range(0, 4095);
        dx  = $urandom_range(0, 60) - 30;
        dy  = $urandom_range(0, 60) - 30;
        burst = $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
            if (kind <= 5) begin
                ang = 6.283185307 * k / len + $urandom_range(0, 99) / 100.0;
                x = clip(cxp + $rtoi(r * $cos(ang)) + $urandom_range(0, 2) - 1);
                y = clip(cyp + $rtoi(r * $sin(ang)) + $urandom_range(0, 2) - 1);
            end else if (kind == 6) begin
                x = clip(x0 + dx * k);
                y = clip(y0 + dy * k);
            end else begin
                x = $urandom_range(0, 4095);
                y = $urandom_range(0, 4095);
            end
            send_point(x, y, k == len - 1);
            if (--burst == 0) begin
                idle_sender($urandom_range(0, 1) ? 0 : $urandom_range(1, 15));
                burst = $urandom_range(1, 12);
            end
        end
    endtask

    initial begin
        sb = new();
        cycle_cnt = 0;
        stall_mode = 0;
        points_sent = 0;
        i_valid = 1'b0;
        i_ready = 1'b1;
        i_point_x = '0;
        i_point_y = '0;
        i_last_point = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fewer than three points.
        send_point(0, 0, 1);
        send_point(4095, 4095, 0);
        send_point(0, 4095, 1);
        // Coincident and collinear points.
        send_point(4095, 4095, 0);
        send_point(4095, 4095, 0);
        send_point(4095, 4095, 1);
        send_point(0, 0, 0);
        send_point(100, 100, 0);
        send_point(4095, 4095, 1);
        // Corner circle with the field extremes.
        send_point(0, 0, 0);
        send_point(4095, 0, 0);
        send_point(0, 4095, 0);
        send_point(4095, 4095, 1);
        // Two nearly collinear contours saturate a center axis and radius, then a triangle.
        send_point(0, 0, 0);
        send_point(2048, 0, 0);
        send_point(4095, 1, 1);
        send_point(0, 2048, 0);
        send_point(1, 4095, 0);
        send_point(0, 0, 1);
        send_point(1365, 2730, 0);
        send_point(2730, 1365, 0);
        send_point(4095, 4095, 1);
        wait_drained();

        while (points_sent < 900) begin
            send_contour();
            if ($urandom_range(0, 14) == 0) wait_drained();
        end

        idle_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
